// ===== rtl/core/midpoint_circle_rasterizer_assert.svh =====
// Assertion macros for the circle rasterizer checker.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define MCR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("circle rasterizer check failed");

// Next-cycle implication, off while reset is asserted.
`define MCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("circle rasterizer check failed");

// Next-cycle implication that also covers the reset cycles.
`define MCR_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("circle rasterizer check failed");

`endif

// ===== rtl/core/mcr_pkg.sv =====
package mcr_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 11;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // pixels emitted for one octant point
    localparam int PIX_PER_POINT = 8;

    // item kinds carried on tuser
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // queue entry: centre x, centre y, octant x (signed), octant y, final flag
    function automatic int entry_width(input int cb);
        return 4 * cb + 2;
    endfunction

endpackage

// ===== rtl/core/mcr_front.sv =====
module mcr_front #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic                                          s_tuser,
    input  logic [COORD_BITS-1:0]                         center_x,
    input  logic [COORD_BITS-1:0]                         center_y,
    input  logic [COORD_BITS-1:0]                         radius,
    input  logic                                          full,
    output logic                                          push,
    output logic [mcr_pkg::entry_width(COORD_BITS)-1:0]   push_data
);
    import mcr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int XW = CB + 1;   // octant x, signed
    localparam int DW = CB + 2;   // step terms, unsigned
    localparam int EW = CB + 5;   // error term, signed

    logic [CB-1:0]        cx_reg, cx_next;
    logic [CB-1:0]        cy_reg, cy_next;
    logic [CB-1:0]        r_reg, r_next;
    logic signed [XW-1:0] x_reg, x_next;
    logic [CB-1:0]        y_reg, y_next;
    logic [DW-1:0]        dx_reg, dx_next;
    logic [DW-1:0]        dy_reg, dy_next;
    logic signed [EW-1:0] err_reg, err_next;
    logic                 drawing_reg, drawing_next;

    logic                 accept;
    logic signed [EW-1:0] err_mid;
    logic signed [EW-1:0] two_r;
    logic                 fin;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (s_tuser == KIND_STEP) && drawing_reg;
    assign two_r    = signed'({{(EW-CB-1){1'b0}}, r_reg, 1'b0});

    // load a circle on a start item, else advance the octant point with the midpoint rule
    always_comb begin
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        r_next       = r_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        err_next     = err_reg;
        drawing_next = drawing_reg;
        err_mid      = err_reg;
        fin          = 1'b0;
        if (accept && s_tuser == KIND_START) begin
            cx_next      = center_x;
            cy_next      = center_y;
            r_next       = radius;
            x_next       = signed'({1'b0, radius}) - XW'(1);
            y_next       = '0;
            dx_next      = DW'(1);
            dy_next      = DW'(1);
            err_next     = EW'(1) - signed'({{(EW-CB-1){1'b0}}, radius, 1'b0});
            drawing_next = (radius != '0);
        end else if (push) begin
            if (err_reg <= 0) begin
                y_next  = y_reg + CB'(1);
                err_mid = err_reg + signed'({{(EW-DW){1'b0}}, dy_reg});
                dy_next = dy_reg + DW'(2);
            end
            err_next = err_mid;
            if (err_mid > 0) begin
                x_next   = x_reg - XW'(1);
                dx_next  = dx_reg + DW'(2);
                err_next = err_mid + signed'({{(EW-DW){1'b0}}, dx_next}) - two_r;
            end
            fin = x_next < signed'({1'b0, y_next});
            if (fin) begin
                drawing_next = 1'b0;
            end
        end
    end

    // queue word holds the point as it was before the update
    assign push_data = {cx_reg, cy_reg, x_reg, y_reg, fin};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg      <= '0;
            cy_reg      <= '0;
            r_reg       <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            dx_reg      <= DW'(1);
            dy_reg      <= DW'(1);
            err_reg     <= '0;
            drawing_reg <= 1'b0;
        end else begin
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            r_reg       <= r_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            err_reg     <= err_next;
            drawing_reg <= drawing_next;
        end
    end

endmodule

// ===== rtl/core/mcr_queue.sv =====
module mcr_queue #(
    parameter int WIDTH = 2,
    parameter int DEPTH = mcr_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);
    import mcr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // advance pointers with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/mcr_back.sv =====
module mcr_back #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          empty,
    input  logic [mcr_pkg::entry_width(COORD_BITS)-1:0]   pop_data,
    output logic                                          pop,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [COORD_BITS+1:0]                         pixel_x,
    output logic [COORD_BITS+1:0]                         pixel_y,
    output logic                                          m_tlast
);
    import mcr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int PB = CB + 2;
    localparam int IW = $clog2(PIX_PER_POINT);
    localparam logic [IW-1:0] LAST_IDX = IW'(PIX_PER_POINT - 1);

    typedef struct packed {
        logic          swap;    // offsets (y, x) instead of (x, y)
        logic          neg_x;
        logic          neg_y;
    } sel_t;

    typedef struct packed {
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        logic [CB:0]   x;
        logic [CB-1:0] y;
        logic          fin;
    } entry_t;

    // symmetry order: (+x,+y) (-x,+y) (+x,-y) (-x,-y) (-y,-x) (+y,-x) (-y,+x) (+y,+x)
    function automatic sel_t pix_sel(input logic [IW-1:0] idx);
        sel_t s;
        s.swap  = (idx >= IW'(4));
        s.neg_x = (idx == IW'(1)) || (idx == IW'(3)) || (idx == IW'(4)) || (idx == IW'(6));
        s.neg_y = (idx == IW'(2)) || (idx == IW'(3)) || (idx == IW'(4)) || (idx == IW'(5));
        return s;
    endfunction

    entry_t        ent_reg, ent_next;
    logic          busy_reg, busy_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          valid_reg, valid_next;
    logic [PB-1:0] px_reg, px_next;
    logic [PB-1:0] py_reg, py_next;
    logic          last_reg, last_next;

    logic          adv;
    sel_t          sel;
    logic [PB-1:0] x_ext;
    logic [PB-1:0] y_ext;
    logic [PB-1:0] off_a;
    logic [PB-1:0] off_b;

    assign adv = busy_reg && (!valid_reg || m_tready);
    assign pop = !empty && (!busy_reg || (adv && idx_reg == LAST_IDX));
    assign sel = pix_sel(idx_reg);

    // pick and sign the offsets for this pixel
    always_comb begin
        x_ext = {ent_reg.x[CB], ent_reg.x};
        y_ext = {2'b00, ent_reg.y};
        off_a = sel.swap ? y_ext : x_ext;
        off_b = sel.swap ? x_ext : y_ext;
    end

    // load the output word and step through the eight pixels
    always_comb begin
        ent_next   = ent_reg;
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_tready;
        px_next    = px_reg;
        py_next    = py_reg;
        last_next  = last_reg;
        if (adv) begin
            valid_next = 1'b1;
            px_next    = {2'b00, ent_reg.cx} + (sel.neg_x ? PB'(0) - off_a : off_a);
            py_next    = {2'b00, ent_reg.cy} + (sel.neg_y ? PB'(0) - off_b : off_b);
            last_next  = (idx_reg == LAST_IDX) && ent_reg.fin;
            idx_next   = idx_reg + IW'(1);
            if (idx_reg == LAST_IDX) begin
                busy_next = 1'b0;
            end
        end
        if (pop) begin
            ent_next  = pop_data;
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
        ent_reg  <= ent_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign pixel_x  = px_reg;
    assign pixel_y  = py_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== rtl/core/midpoint_circle_rasterizer.sv =====
// Channel  Dir  tdata (low bit up)                     tuser / tlast
// s_       in   center_x, center_y, radius, zero pad   tuser: kind (0 start, 1 step)
// m_       out  pixel_x, pixel_y, zero pad             tlast: last_pixel
//
// A start item yields nothing when taken; a step item while a
// circle is active updates the octant point in the cycle it is taken.
// Each active step yields eight pixels, one per cycle from the output
// register while the output is not stalled.
// A two-word queue between the point update and the pixel expansion lets
// the input keep flowing while the output stalls, until the queue is full.
// Reset is synchronous, active low, and clears all control state.
module midpoint_circle_rasterizer #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // center_x, center_y, radius, zero pad
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]          s_tdata,
    // kind
    input  logic                                       s_tuser,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // pixel_x, pixel_y, zero pad
    output logic [((2*(COORD_BITS+2)+7)/8)*8-1:0]      m_tdata,
    output logic                                       m_tlast
);
    import mcr_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int PB    = CB + 2;
    localparam int EN_W  = entry_width(CB);
    localparam int OUT_W = ((2*PB+7)/8)*8;

    logic            push;
    logic [EN_W-1:0] push_data;
    logic            full;
    logic            pop;
    logic            empty;
    logic [EN_W-1:0] pop_data;
    logic [PB-1:0]   pixel_x;
    logic [PB-1:0]   pixel_y;

    mcr_front #(.COORD_BITS(CB)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .center_x  (s_tdata[CB-1:0]),
        .center_y  (s_tdata[2*CB-1:CB]),
        .radius    (s_tdata[3*CB-1:2*CB]),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    mcr_queue #(.WIDTH(EN_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .pop_data  (pop_data)
    );

    mcr_back #(.COORD_BITS(CB)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .m_tlast  (m_tlast)
    );

    // pack the output word, zero pad on top
    assign m_tdata = {{(OUT_W-2*PB){1'b0}}, pixel_y, pixel_x};

endmodule

// ===== rtl/core/mcr_checker.sv =====
`include "midpoint_circle_rasterizer_assert.svh"

module mcr_checker #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_tvalid,
    input logic                                   s_tready,
    input logic                                   s_tuser,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((2*(COORD_BITS+2)+7)/8)*8-1:0]  m_tdata,
    input logic                                   m_tlast
);
    import mcr_pkg::*;

    logic seen_step_reg;

    // note whether any step word has been taken since reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_step_reg <= 1'b0;
        end else if (s_tvalid && s_tready && s_tuser == KIND_STEP) begin
            seen_step_reg <= 1'b1;
        end
    end

    `MCR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `MCR_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
    `MCR_ASSERT_ALWAYS(a_reset_clears, !aresetn, !m_tvalid)
    `MCR_ASSERT_NOW(a_no_pixel_without_step, !seen_step_reg, !m_tvalid)

endmodule

bind midpoint_circle_rasterizer mcr_checker #(.COORD_BITS(COORD_BITS)) u_mcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/tb_midpoint_circle_rasterizer.sv =====
module tb_midpoint_circle_rasterizer;
    timeunit 1ns;
    timeprecision 1ps;

    import mcr_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int PIX_W       = CB + 2;
    localparam int S_W         = ((3 * CB + 7) / 8) * 8;
    localparam int M_W         = ((2 * PIX_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 32;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic             last;
    } pixel_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;
    logic           s_tuser  = KIND_START;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic           m_tlast;

    // pixels still owed by the block, oldest first
    pixel_t pixel_q[$];

    // circle state as the block should hold it
    int ctr_x, ctr_y, rad;
    int oct_x, oct_y, step_x, step_y, err_acc;
    bit circle_on;

    int          words_used;
    int          mismatch_count;
    int          src_idle_pct;
    int          sink_idle_pct;
    int unsigned hold_target;
    int unsigned hold_count;
    int unsigned cycle_count;

    midpoint_circle_rasterizer #(
        .COORD_BITS(CB)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #6 aclk = ~aclk;

    // end the run if it hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // drive ready: long hold-off when requested, otherwise random idling
    always @(posedge aclk) begin
        if (hold_count < hold_target) begin
            hold_count <= hold_count + 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %0d at cycle %0d: %s", mismatch_count, cycle_count, msg);
    endtask

    task automatic push_pixel(input int px, input int py, input bit last);
        pixel_t p;
        p.px   = PIX_W'(px);
        p.py   = PIX_W'(py);
        p.last = last;
        pixel_q.push_back(p);
    endtask

    // advance the circle state for one accepted word and queue its pixels
    task automatic rasterize_word(input logic kind, input logic [CB-1:0] cx,
                                  input logic [CB-1:0] cy, input logic [CB-1:0] r);
        int x, y;
        bit fin;
        if (kind == KIND_START) begin
            ctr_x     = int'(cx);
            ctr_y     = int'(cy);
            rad       = int'(r);
            oct_x     = rad - 1;
            oct_y     = 0;
            step_x    = 1;
            step_y    = 1;
            err_acc   = step_x - 2 * rad;
            circle_on = (oct_x >= oct_y);
            words_used++;
        end else if (circle_on) begin
            x = oct_x;
            y = oct_y;
            // midpoint rule: move y first, then x if the error went positive
            if (err_acc <= 0) begin
                oct_y   += 1;
                err_acc += step_y;
                step_y  += 2;
            end
            if (err_acc > 0) begin
                oct_x   -= 1;
                step_x  += 2;
                err_acc += step_x - 2 * rad;
            end
            fin = (oct_x < oct_y);
            if (fin)
                circle_on = 1'b0;
            push_pixel(ctr_x + x, ctr_y + y, 1'b0);
            push_pixel(ctr_x - x, ctr_y + y, 1'b0);
            push_pixel(ctr_x + x, ctr_y - y, 1'b0);
            push_pixel(ctr_x - x, ctr_y - y, 1'b0);
            push_pixel(ctr_x - y, ctr_y - x, 1'b0);
            push_pixel(ctr_x + y, ctr_y - x, 1'b0);
            push_pixel(ctr_x - y, ctr_y + x, 1'b0);
            push_pixel(ctr_x + y, ctr_y + x, fin);
            words_used++;
        end
    endtask

    // offer one word after a random gap, hold it until taken
    task automatic send_word(input logic kind, input logic [CB-1:0] cx,
                             input logic [CB-1:0] cy, input logic [CB-1:0] r);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_W'({r, cy, cx});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        rasterize_word(kind, cx, cy, r);
    endtask

    task automatic send_step_noise();
        send_word(KIND_STEP, CB'($urandom), CB'($urandom), CB'($urandom));
    endtask

    // compare each pixel word with the oldest one owed
    always @(posedge aclk) begin
        pixel_t want;
        logic [PIX_W-1:0] got_x, got_y;
        if (aresetn && m_tvalid && m_tready) begin
            got_x = m_tdata[PIX_W-1:0];
            got_y = m_tdata[2*PIX_W-1:PIX_W];
            if (pixel_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                    $signed(got_x), $signed(got_y), m_tlast));
            end else begin
                want = pixel_q.pop_front();
                if (got_x !== want.px || got_y !== want.py || m_tlast !== want.last)
                    flag_mismatch($sformatf(
                        "expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                        $signed(want.px), $signed(want.py), want.last,
                        $signed(got_x), $signed(got_y), m_tlast));
            end
        end
    end

    // corners of the coordinate range and each special case
    task automatic test_directed_cases();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // step while idle after reset: dropped
        send_step_noise();
        // zero radius never becomes active
        send_word(KIND_START, '0, '0, '0);
        send_step_noise();
        // radius one: a single point
        send_word(KIND_START, CB'(5), CB'(5), CB'(1));
        send_step_noise();
        // largest circle on the top corner, then abandon it for the origin
        send_word(KIND_START, {CB{1'b1}}, {CB{1'b1}}, {CB{1'b1}});
        repeat (3) send_step_noise();
        send_word(KIND_START, '0, '0, {CB{1'b1}});
        repeat (2) send_step_noise();
        // small full circles at the edges, then a stray step after the end
        send_word(KIND_START, {CB{1'b1}}, '0, CB'(2));
        while (circle_on)
            send_step_noise();
        send_step_noise();
        send_word(KIND_START, '0, {CB{1'b1}}, CB'(4));
        while (circle_on)
            send_word(KIND_STEP, {CB{1'b1}}, {CB{1'b1}}, {CB{1'b1}});
        send_word(KIND_STEP, '0, '0, '0);
    endtask

    // mostly whole circles with random content, some cut short, some noise
    task automatic test_random_circles(input int src_pct, input int sink_pct,
                                       input int budget);
        int first, sel, steps;
        logic [CB-1:0] r;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        first = words_used;
        while (words_used - first < budget) begin
            sel = $urandom_range(99);
            if (sel < 8)
                r = '0;
            else if (sel < 16)
                r = CB'($urandom);
            else if (sel < 26)
                r = CB'($urandom_range(60, 17));
            else
                r = CB'($urandom_range(16, 1));
            send_word(KIND_START, CB'($urandom), CB'($urandom), r);
            // cut large circles and a few small ones short
            if (r > 60 || $urandom_range(99) < 15)
                steps = $urandom_range(12, 1);
            else
                steps = 1 << 30;
            while (circle_on && steps > 0) begin
                send_step_noise();
                steps--;
            end
            if ($urandom_range(99) < 20)
                send_step_noise();
        end
    endtask

    // hold the receiver off while steps keep coming, so the input stalls
    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_target   = hold_count + 300;
        send_word(KIND_START, CB'($urandom), CB'($urandom), CB'(24));
        repeat (20) send_step_noise();
        while (circle_on)
            send_step_noise();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_circles(11, 54, 135);
        test_output_backpressure();
        test_random_circles(54, 11, 135);
        test_random_circles(0, 0, 135);

        // drop valid and let every owed pixel come out
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatch_count == 0 && pixel_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mcr_pkg.sv
rtl/core/mcr_front.sv
rtl/core/mcr_queue.sv
rtl/core/mcr_back.sv
rtl/core/midpoint_circle_rasterizer.sv
rtl/core/mcr_checker.sv
tb/tb_midpoint_circle_rasterizer.sv
